// File: hdl/fte_pkg.sv
`timescale 1ns / 1ps

package fte_pkg;

    // ascii codes and limits
    localparam logic [6:0] NEWLINE_CODE = 7'd10;
    localparam logic [6:0] ALPHA_BASE   = 7'd65;
    localparam logic [6:0] DIGIT_BASE   = 7'd48;
    localparam logic [4:0] ALPHA_COUNT  = 5'd26;
    localparam logic [7:0] WIDTH_RESET  = 8'd72;
    localparam logic [7:0] WIDTH_MIN    = 8'd2;

    // input command codes
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // one queue entry: the 5-bit groups one input word produced
    typedef struct packed {
        logic       flush;
        logic [1:0] n_groups;
        logic [4:0] g0;
        logic [4:0] g1;
    } fte_entry_t;

    // 5-bit group to ascii character
    function automatic logic [6:0] char_of(input logic [4:0] group);
        logic [6:0] ch;
        if (group < ALPHA_COUNT)
        begin
            ch = ALPHA_BASE + {2'b00, group};
        end
        else
        begin
            ch = DIGIT_BASE + {2'b00, group - ALPHA_COUNT};
        end
        return ch;
    endfunction

endpackage

// File: hdl/five_bit_text_encoder.sv
`timescale 1ns / 1ps

// channel   direction  tdata / data             tuser / tlast
// s_*       in         [7:0] data_byte          tuser: cmd (0 data, 1 flush)
// m_*       out        [6:0] out_char, [7] 0    tlast: final word of an input
// cfg_*     in         [7:0] line_width         none
//
// a data word is taken every cycle while the queue has room; the back end puts
// out one character or newline per cycle while the output is not stalled, so
// sustained rate is set by that output stage and by inserted newlines; a flush
// ends with a closing newline, or with no output word when the line is empty
// reset clears bit buffer, line count, queue and output; line width returns to 72
// either side can stall on its own: the queue and the output register part them

module five_bit_text_encoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tuser,   // [0] cmd
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [6:0] out_char, [7] zero
    output logic       m_tlast,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data   // [7:0] line_width
);
    import fte_pkg::*;

    fte_entry_t wr_entry;
    fte_entry_t head;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    logic [7:0] width_reg;
    logic [6:0] out_char;

    // line width register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= WIDTH_RESET;
        end
        else if (cfg_valid)
        begin
            width_reg <= cfg_data;
        end
    end

    assign s_tready = !full;
    assign push     = s_tvalid && !full;
    assign m_tdata  = {1'b0, out_char};

    fte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .cmd       (s_tuser),
        .data_byte (s_tdata),
        .entry     (wr_entry)
    );

    fte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_entry (wr_entry),
        .pop      (pop),
        .rd_entry (head),
        .full     (full),
        .empty    (empty)
    );

    fte_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_width (width_reg),
        .head_valid (!empty),
        .head       (head),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (out_char),
        .out_last   (m_tlast)
    );

endmodule

// File: hdl/fte_front.sv
`timescale 1ns / 1ps

module fte_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic                cmd,
    input  logic [7:0]          data_byte,
    output fte_pkg::fte_entry_t entry
);
    import fte_pkg::*;

    logic [3:0]  buf_reg;
    logic [3:0]  buf_next;
    logic [2:0]  bc_reg;
    logic [2:0]  bc_next;
    logic [11:0] combined;
    logic [3:0]  cnt;
    logic        two;
    logic [3:0]  rem;
    logic [3:0]  sh0;
    logic [3:0]  sh1;
    logic [2:0]  fsh;
    logic [7:0]  fbuf;

    // split the pending bits plus the new byte into groups
    always_comb
    begin
        combined = {buf_reg, data_byte};
        cnt      = {1'b0, bc_reg} + 4'd8;
        two      = (cnt >= 4'd10);
        sh0      = cnt - 4'd5;
        sh1      = cnt - 4'd10;
        rem      = two ? sh1 : sh0;
        fsh      = 3'd5 - bc_reg;
        fbuf     = {4'b0000, buf_reg} << fsh;
        entry    = '0;
        buf_next = buf_reg;
        bc_next  = bc_reg;
        if (cmd == CMD_FLUSH)
        begin
            entry.flush    = 1'b1;
            entry.n_groups = (bc_reg != 3'd0) ? 2'd1 : 2'd0;
            entry.g0       = fbuf[4:0];
            buf_next       = 4'd0;
            bc_next        = 3'd0;
        end
        else
        begin
            entry.flush    = 1'b0;
            entry.n_groups = two ? 2'd2 : 2'd1;
            entry.g0       = 5'(combined >> sh0);
            entry.g1       = 5'(combined >> sh1);
            buf_next       = 4'(combined & ((12'd1 << rem) - 12'd1));
            bc_next        = rem[2:0];
        end
    end

    // leftover bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg <= 4'd0;
            bc_reg  <= 3'd0;
        end
        else if (push)
        begin
            buf_reg <= buf_next;
            bc_reg  <= bc_next;
        end
    end

endmodule

// File: hdl/fte_queue.sv
`timescale 1ns / 1ps

module fte_queue #(
    parameter int DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  fte_pkg::fte_entry_t wr_entry,
    input  logic                pop,
    output fte_pkg::fte_entry_t rd_entry,
    output logic                full,
    output logic                empty
);
    import fte_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fte_entry_t       entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign rd_entry = entries_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hdl/fte_back.sv
`timescale 1ns / 1ps

module fte_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          line_width,
    input  logic                head_valid,
    input  fte_pkg::fte_entry_t head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [6:0]          out_char,
    output logic                out_last
);
    import fte_pkg::*;

    logic [1:0] idx_reg;
    logic [1:0] idx_next;
    logic [7:0] lc_reg;
    logic [7:0] lc_next;
    logic       ov_reg;
    logic [6:0] oc_reg;
    logic       ol_reg;
    logic       out_free;
    logic       emit;
    logic [6:0] emit_char;
    logic       emit_last;
    logic [7:0] w;
    logic       final_grp;
    logic [4:0] grp;

    assign out_free  = !ov_reg || out_ready;
    assign out_valid = ov_reg;
    assign out_char  = oc_reg;
    assign out_last  = ol_reg;

    // one character or newline per cycle from the head entry, while the output register is free
    always_comb
    begin
        w         = (line_width < WIDTH_MIN) ? WIDTH_MIN : line_width;
        final_grp = (idx_reg == head.n_groups - 2'd1);
        grp       = (idx_reg == 2'd0) ? head.g0 : head.g1;
        emit      = 1'b0;
        emit_char = NEWLINE_CODE;
        emit_last = 1'b0;
        pop       = 1'b0;
        idx_next  = idx_reg;
        lc_next   = lc_reg;
        if (head_valid && out_free)
        begin
            if (idx_reg < head.n_groups)
            begin
                emit = 1'b1;
                if (lc_reg >= w)
                begin
                    lc_next = 8'd0;
                end
                else
                begin
                    emit_char = char_of(grp);
                    lc_next   = lc_reg + 8'd1;
                    emit_last = final_grp && !head.flush;
                    if (final_grp && !head.flush)
                    begin
                        pop      = 1'b1;
                        idx_next = 2'd0;
                    end
                    else
                    begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end
            else
            begin
                // flush tail: closing newline on a non-empty line
                emit      = (lc_reg != 8'd0);
                emit_last = 1'b1;
                pop       = 1'b1;
                idx_next  = 2'd0;
                lc_next   = 8'd0;
            end
        end
    end

    // sequencing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
            lc_reg  <= 8'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            idx_reg <= idx_next;
            lc_reg  <= lc_next;
            if (out_free)
            begin
                ov_reg <= emit;
            end
        end
    end

    // output word register
    always_ff @(posedge clk)
    begin
        if (out_free && emit)
        begin
            oc_reg <= emit_char;
            ol_reg <= emit_last;
        end
    end

endmodule

// File: hdl/fte_checker.sv
`timescale 1ns / 1ps

module fte_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    // only the encoding alphabet or newline appears
    a_alphabet: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == 8'd10)
                  || (m_tdata >= 8'd65 && m_tdata <= 8'd90)
                  || (m_tdata >= 8'd48 && m_tdata <= 8'd53))
        else $error("output word outside the alphabet");

    // an inserted line break is followed by its character, never another break
    a_no_double_nl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tdata == 8'd10 && !m_tlast
        |=> m_tvalid && m_tdata != 8'd10)
        else $error("inserted newline not followed by a character");

    // a non-final line break is never followed by a final line break
    a_nl_not_last_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && m_tdata == 8'd10 && !m_tlast |=> !m_tlast || m_tdata != 8'd10)
        else $error("inserted newline closed an item");

endmodule

bind five_bit_text_encoder fte_checker u_fte_checker (.*);

// File: tb/tb_five_bit_text_encoder.sv
`timescale 1ns / 1ps

module tb_five_bit_text_encoder;

    import fte_pkg::*;

    localparam int DRAIN_CYCLES = 24;
    localparam int GAP_PCT      = 72;
    localparam int BOTH_PCT     = 31;

    // one input word: command in tuser, byte in tdata
    typedef struct packed {
        logic       cmd;
        logic [7:0] data;
    } stream_item_t;

    // one output word: ascii code and end-of-input mark
    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } char_word_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'd0;
    logic       s_tuser = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'd0;

    stream_item_t pending_items[$];
    char_word_t   expected_chars[$];
    char_word_t   fresh_chars[$];

    // encoder state as predicted
    logic [11:0] held_bits = 12'd0;
    logic [3:0]  held_count = 4'd0;
    logic [7:0]  line_chars = 8'd0;
    logic [7:0]  line_width_model = WIDTH_RESET;

    int send_gap_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;

    five_bit_text_encoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // 5-bit group to ascii
    function automatic logic [6:0] group_to_ascii(input logic [4:0] group);
        if (group < ALPHA_COUNT)
        begin
            return ALPHA_BASE + 7'(group);
        end
        return DIGIT_BASE + 7'(group - ALPHA_COUNT);
    endfunction

    // one character, with a line break first when the line is full
    function automatic void emit_char(input logic [4:0] group);
        logic [7:0] eff_width;
        eff_width = (line_width_model < WIDTH_MIN) ? WIDTH_MIN : line_width_model;
        if (line_chars >= eff_width)
        begin
            fresh_chars.push_back('{NEWLINE_CODE, 1'b0});
            line_chars = 8'd0;
        end
        fresh_chars.push_back('{group_to_ascii(group), 1'b0});
        line_chars = line_chars + 8'd1;
    endfunction

    // characters that one accepted input word produces
    function automatic void predict_chars(input logic cmd, input logic [7:0] data);
        logic [4:0] group;
        fresh_chars.delete();
        if (cmd == CMD_DATA)
        begin
            held_bits = {held_bits[3:0], data};
            held_count = held_count + 4'd8;
            while (held_count >= 4'd5)
            begin
                group = 5'(held_bits >> (held_count - 4'd5));
                held_count = held_count - 4'd5;
                emit_char(group);
            end
            held_bits = held_bits & 12'((12'd1 << held_count) - 12'd1);
        end
        else
        begin
            // leftover bits padded with zeros on the right
            if (held_count > 4'd0)
            begin
                group = 5'(held_bits << (4'd5 - held_count));
                emit_char(group);
            end
            if (line_chars > 8'd0)
            begin
                fresh_chars.push_back('{NEWLINE_CODE, 1'b0});
            end
            held_bits = 12'd0;
            held_count = 4'd0;
            line_chars = 8'd0;
        end
        if (fresh_chars.size() > 0)
        begin
            fresh_chars[fresh_chars.size() - 1].last = 1'b1;
        end
        foreach (fresh_chars[i])
        begin
            expected_chars.push_back(fresh_chars[i]);
        end
    endfunction

    // driver: feeds queued words, predicts on each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= 8'd0;
            s_tuser <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_chars(s_tuser, s_tdata);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_items[0].cmd;
                    s_tdata <= pending_items[0].data;
                    void'(pending_items.pop_front());
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted word against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        char_word_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_chars.size() == 0)
                begin
                    $error("unexpected word: out_char %0d last %0b", m_tdata[6:0], m_tlast);
                    error_count++;
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (m_tdata[6:0] !== want.code)
                    begin
                        $error("out_char: expected %0d, actual %0d", want.code, m_tdata[6:0]);
                        error_count++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, m_tlast);
                        error_count++;
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic push_item(input logic cmd, input logic [7:0] data);
        pending_items.push_back('{cmd, data});
    endtask

    // wait until no word is queued, in flight or expected
    task automatic wait_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || s_tvalid || expected_chars.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_line_width(input logic [7:0] width);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= width;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        line_width_model = width;
        cfg_valid <= 1'b0;
    endtask

    // runs of random bytes closed by a flush, then a few unflushed bytes
    task automatic run_phase(input bit write_cfg, input logic [7:0] width,
                             input int gap_pct, input int stall_pct, input int n_items);
        int count;
        int run_len;
        send_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        if (write_cfg)
        begin
            write_line_width(width);
        end
        count = 0;
        while (count < n_items)
        begin
            run_len = ($urandom_range(7) == 0) ? 0 : $urandom_range(1, 12);
            for (int k = 0; k < run_len; k++)
            begin
                push_item(CMD_DATA, 8'($urandom));
            end
            push_item(CMD_FLUSH, 8'($urandom));
            count += run_len + 1;
        end
        run_len = $urandom_range(0, 6);
        for (int k = 0; k < run_len; k++)
        begin
            push_item(CMD_DATA, 8'($urandom));
        end
        wait_idle();
    endtask

    // stimulus and phases
    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty flush with a nonzero byte, all-zero and all-one data
        push_item(CMD_FLUSH, 8'hFF);
        push_item(CMD_DATA, 8'h00);
        push_item(CMD_FLUSH, 8'h00);
        for (int k = 0; k < 5; k++)
        begin
            push_item(CMD_DATA, 8'hFF);
        end
        // no pending bits but a nonempty line: newline only
        push_item(CMD_FLUSH, 8'h00);
        push_item(CMD_FLUSH, 8'hA5);
        push_item(CMD_DATA, 8'h55);
        push_item(CMD_DATA, 8'hAA);
        push_item(CMD_DATA, 8'h80);
        push_item(CMD_DATA, 8'h01);
        push_item(CMD_FLUSH, 8'h7F);

        run_phase(1'b0, WIDTH_RESET, 0, 0, 30);
        // leave a long open line so the next width is already exceeded
        for (int k = 0; k < 10; k++)
        begin
            push_item(CMD_DATA, 8'($urandom));
        end
        wait_idle();

        run_phase(1'b1, 8'd3, GAP_PCT, 0, 38);
        run_phase(1'b1, 8'd1, 0, GAP_PCT, 38);
        run_phase(1'b1, 8'd255, BOTH_PCT, BOTH_PCT, 38);
        run_phase(1'b1, 8'($urandom_range(1, 255)), 0, 0, 38);
        run_phase(1'b1, 8'd2, GAP_PCT, 0, 38);
        run_phase(1'b1, 8'($urandom_range(1, 20)), 0, GAP_PCT, 38);
        run_phase(1'b1, 8'($urandom_range(4, 12)), BOTH_PCT, BOTH_PCT, 38);

        if (error_count == 0)
        begin
            $display("five_bit_text_encoder test passed");
        end
        else
        begin
            $display("five_bit_text_encoder test failed");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #2ms;
        $display("five_bit_text_encoder test failed");
        $finish;
    end

endmodule
